// ----- hdl/hill_pkg.sv -----
// shared types, constants and mod-26 helpers for the 2x2 hill cipher decryptor
// no dependencies; imported by every hill_* module
package hill_pkg;

    localparam int CHAR_W     = 8;
    localparam int LETTER_W   = 5;
    localparam int KEY_W      = 5;
    localparam int PROD_W     = 10;
    localparam int SUM_W      = 11;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;
    localparam int QCNT_W     = 3;
    localparam int SETTLE_W   = 2;

    localparam logic [LETTER_W-1:0] ALPHA      = 5'd26;
    localparam logic [CHAR_W-1:0]   BASE_CHAR  = 8'd97;
    // 260 - 97, keeps the letter offset non-negative
    localparam logic [SUM_W-1:0]    LETTER_OFS = 11'd163;
    // 26 * 26, keeps the determinant non-negative
    localparam logic [SUM_W-1:0]    DET_OFS    = 11'd676;
    // cycles the derived key needs after a register write
    localparam logic [SETTLE_W-1:0] KEY_SETTLE = 2'd3;

    localparam logic [LETTER_W-1:0] INV_TABLE [26] = '{
        5'd0, 5'd1, 5'd0, 5'd9, 5'd0, 5'd21, 5'd0, 5'd15, 5'd0, 5'd3, 5'd0, 5'd19, 5'd0,
        5'd0, 5'd0, 5'd7, 5'd0, 5'd23, 5'd0, 5'd11, 5'd0, 5'd5, 5'd0, 5'd17, 5'd0, 5'd25
    };

    typedef enum logic [1:0] {
        CFG_KEY_A = 2'd0,
        CFG_KEY_B = 2'd1,
        CFG_KEY_C = 2'd2,
        CFG_KEY_D = 2'd3
    } cfg_index_t;

    typedef enum logic {
        KIND_PASS = 1'b0,
        KIND_PAIR = 1'b1
    } entry_kind_t;

    typedef struct packed {
        logic [CHAR_W-1:0] in_char;
        logic              end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              last_of_run;
        logic              key_invertible;
    } out_item_t;

    typedef struct packed {
        logic [LETTER_W-1:0] ia;
        logic [LETTER_W-1:0] ib;
        logic [LETTER_W-1:0] ic;
        logic [LETTER_W-1:0] id;
        logic                invertible;
        logic                busy;
    } key_coef_t;

    typedef struct packed {
        entry_kind_t         kind;
        logic [CHAR_W-1:0]   raw;
        logic [LETTER_W-1:0] x0;
        logic [LETTER_W-1:0] x1;
    } qentry_t;

    // x mod 26 by reciprocal multiply (2521 / 2^16) and one correction step
    function automatic logic [LETTER_W-1:0] mod26(input logic [SUM_W-1:0] x);
        logic [22:0] prod;
        logic [6:0]  q;
        logic [11:0] r;
        prod = {12'd0, x} * 23'd2521;
        q    = prod[22:16];
        r    = {1'b0, x} - ({5'd0, q} * 12'd26);
        if (r >= 12'd26)
        begin
            r = r - 12'd26;
        end
        return r[LETTER_W-1:0];
    endfunction

    function automatic logic [LETTER_W-1:0] mul_mod26(input logic [LETTER_W-1:0] a,
                                                      input logic [LETTER_W-1:0] b);
        logic [SUM_W-1:0] p;
        p = {6'd0, a} * {6'd0, b};
        return mod26(p);
    endfunction

    function automatic logic [LETTER_W-1:0] letter_of(input logic [CHAR_W-1:0] ch);
        return mod26({3'd0, ch} + LETTER_OFS);
    endfunction

endpackage

// ----- hdl/hill_key.sv -----
// key registers and the derived inverse key matrix, built over a short pipeline
// depends on hill_pkg
module hill_key (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  hill_pkg::cfg_index_t        cfg_index,
    input  logic [hill_pkg::KEY_W-1:0]  cfg_data,
    output hill_pkg::key_coef_t         coef
);
    import hill_pkg::*;

    logic [KEY_W-1:0]    a_reg, b_reg, c_reg, d_reg;
    logic [KEY_W-1:0]    key_next;
    logic [PROD_W-1:0]   ad_reg, bc_reg;
    logic [LETTER_W-1:0] det_reg, det_next;
    logic [LETTER_W-1:0] inv_reg;
    logic [LETTER_W-1:0] ia_reg, ib_reg, ic_reg, id_reg;
    logic [LETTER_W-1:0] b_neg, c_neg;
    logic [SETTLE_W-1:0] settle_reg, settle_next;

    // entries are kept already reduced mod 26
    always_comb
    begin
        key_next = (cfg_data >= ALPHA) ? (cfg_data - ALPHA) : cfg_data;
        det_next = mod26({1'b0, ad_reg} + DET_OFS - {1'b0, bc_reg});
        b_neg    = (b_reg == '0) ? '0 : (ALPHA - b_reg);
        c_neg    = (c_reg == '0) ? '0 : (ALPHA - c_reg);
        if (cfg_we)
        begin
            settle_next = KEY_SETTLE;
        end
        else if (settle_reg != '0)
        begin
            settle_next = settle_reg - 1'b1;
        end
        else
        begin
            settle_next = settle_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg      <= '0;
            b_reg      <= '0;
            c_reg      <= '0;
            d_reg      <= '0;
            ad_reg     <= '0;
            bc_reg     <= '0;
            det_reg    <= '0;
            inv_reg    <= '0;
            ia_reg     <= '0;
            ib_reg     <= '0;
            ic_reg     <= '0;
            id_reg     <= '0;
            settle_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_KEY_A: a_reg <= key_next;
                    CFG_KEY_B: b_reg <= key_next;
                    CFG_KEY_C: c_reg <= key_next;
                    CFG_KEY_D: d_reg <= key_next;
                    default:   a_reg <= a_reg;
                endcase
            end
            ad_reg     <= {5'd0, a_reg} * {5'd0, d_reg};
            bc_reg     <= {5'd0, b_reg} * {5'd0, c_reg};
            det_reg    <= det_next;
            inv_reg    <= INV_TABLE[det_reg];
            ia_reg     <= mul_mod26(inv_reg, d_reg);
            ib_reg     <= mul_mod26(inv_reg, b_neg);
            ic_reg     <= mul_mod26(inv_reg, c_neg);
            id_reg     <= mul_mod26(inv_reg, a_reg);
            settle_reg <= settle_next;
        end
    end

    // inverse matrix lands the cycle after invertibility; the back end reads it later still
    assign coef = '{ia: ia_reg, ib: ib_reg, ic: ic_reg, id: id_reg,
                    invertible: (inv_reg != '0),
                    busy: (settle_reg != '0) || cfg_we};

    a_busy_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> coef.busy)
        else $error("key pipeline not busy after a write");

endmodule

// ----- hdl/hill_front.sv -----
// input side: takes characters, pairs them up and classifies them into queue entries
// depends on hill_pkg
module hill_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  hill_pkg::in_item_t  in_data,
    input  hill_pkg::key_coef_t coef,
    input  logic                q_full,
    output logic                q_push,
    output hill_pkg::qentry_t   q_entry
);
    import hill_pkg::*;

    logic                pending_reg, pending_next;
    logic [LETTER_W-1:0] held_reg, held_next;
    logic [LETTER_W-1:0] letter;
    logic                accept;

    always_comb
    begin
        in_ready     = !coef.busy && !q_full;
        accept       = in_valid && in_ready;
        letter       = letter_of(in_data.in_char);
        q_push       = 1'b0;
        q_entry      = '{kind: KIND_PASS, raw: in_data.in_char, x0: held_reg, x1: letter};
        pending_next = pending_reg;
        held_next    = held_reg;
        if (accept)
        begin
            if (!coef.invertible)
            begin
                q_push       = 1'b1;
                pending_next = 1'b0;
            end
            else if (!pending_reg)
            begin
                // odd char carrying the end mark is dropped
                pending_next = !in_data.end_of_message;
                held_next    = letter;
            end
            else
            begin
                q_push       = 1'b1;
                q_entry.kind = KIND_PAIR;
                pending_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

endmodule

// ----- hdl/hill_fifo.sv -----
// short queue of classified entries between the front and back ends
// depends on hill_pkg
module hill_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  hill_pkg::qentry_t entry_in,
    output logic              full,
    input  logic              pop,
    output hill_pkg::qentry_t entry_out,
    output logic              empty
);
    import hill_pkg::*;

    qentry_t             mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        full       = (count_reg == QCNT_W'(QDEPTH));
        empty      = (count_reg == '0);
        entry_out  = mem[rd_ptr_reg];
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= entry_in;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue read while empty");

endmodule

// ----- hdl/hill_back.sv -----
// back end: matrix products or pass-through, mod-26 reduction and the output register
// depends on hill_pkg
module hill_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  hill_pkg::qentry_t   q_head,
    output logic                q_pop,
    input  hill_pkg::key_coef_t coef,
    output logic                out_valid,
    input  logic                out_ready,
    output hill_pkg::out_item_t out_data
);
    import hill_pkg::*;

    logic              s1_valid_reg, s1_valid_next;
    logic              s1_phase_reg, s1_phase_next;
    entry_kind_t       s1_kind_reg;
    logic [CHAR_W-1:0] s1_raw_reg;
    logic [SUM_W-1:0]  s1_sum0_reg, s1_sum1_reg;
    logic [SUM_W-1:0]  sum0, sum1;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg, out_next;
    logic              s2_load, s1_done;

    always_comb
    begin
        sum0 = ({6'd0, coef.ia} * {6'd0, q_head.x0}) + ({6'd0, coef.ib} * {6'd0, q_head.x1});
        sum1 = ({6'd0, coef.ic} * {6'd0, q_head.x0}) + ({6'd0, coef.id} * {6'd0, q_head.x1});

        s2_load = s1_valid_reg && (!out_valid_reg || out_ready);
        s1_done = s2_load && ((s1_kind_reg == KIND_PASS) || s1_phase_reg);
        q_pop   = !q_empty && (!s1_valid_reg || s1_done);

        s1_valid_next = q_pop ? 1'b1 : (s1_done ? 1'b0 : s1_valid_reg);
        s1_phase_next = q_pop ? 1'b0 : ((s2_load && !s1_done) ? 1'b1 : s1_phase_reg);

        case (s1_kind_reg)
            KIND_PAIR:
            begin
                out_next.out_char       = {3'd0, mod26(s1_phase_reg ? s1_sum1_reg : s1_sum0_reg)}
                                          + BASE_CHAR;
                out_next.last_of_run    = s1_phase_reg;
                out_next.key_invertible = 1'b1;
            end
            default:
            begin
                out_next.out_char       = s1_raw_reg;
                out_next.last_of_run    = 1'b1;
                out_next.key_invertible = 1'b0;
            end
        endcase

        out_valid_next = s2_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_phase_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s1_phase_reg  <= s1_phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_kind_reg <= q_head.kind;
            s1_raw_reg  <= q_head.raw;
            s1_sum0_reg <= sum0;
            s1_sum1_reg <= sum1;
        end
        if (s2_load)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_phase_only_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_phase_reg) |-> (s1_kind_reg == KIND_PAIR))
        else $error("second beat on a pass-through entry");

    a_pop_frees_stage: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> s1_valid_reg && !s1_phase_reg)
        else $error("work stage not loaded after pop");

endmodule

// ----- hdl/hill_2x2_decrypt_top.sv -----
// top level of the 2x2 hill cipher decryptor: key unit, front end, queue, back end
// depends on hill_pkg, hill_key, hill_front, hill_fifo, hill_back
//
// usage:
//   in channel (in_valid/in_ready/in_data) takes one ciphertext byte per beat, with an
//   end-of-message flag. out channel (out_valid/out_ready/out_data) gives decrypted letters.
//   with an invertible key each second character of a pair yields two beats; the first
//   character yields none, and an odd character carrying the end mark is dropped.
//   with a non-invertible key every byte comes back unchanged in one beat.
//   key registers are written through cfg_we/cfg_index/cfg_data; in_ready is low in the
//   write cycle and after it while the inverse key is rebuilt.
//   a result passes the queue write, the product stage and the output register in that
//   order; the second of a pair comes from the same product stage once the output is free.
//   throughput: one input beat per cycle while in_ready is high; the back end drains one
//   result per cycle while out_ready is high, set by its single output register, and the
//   4-entry queue absorbs pair bursts. a stalled receiver holds the output register, then
//   the back end, then fills the queue, after which in_ready drops.
//   reset clears the key to zero (not invertible), the pairing state and the queue.
module hill_2x2_decrypt_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  hill_pkg::in_item_t          in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output hill_pkg::out_item_t         out_data,
    input  logic                        cfg_we,
    input  hill_pkg::cfg_index_t        cfg_index,
    input  logic [hill_pkg::KEY_W-1:0]  cfg_data
);
    import hill_pkg::*;

    key_coef_t coef;
    qentry_t   push_entry, head_entry;
    logic      q_push, q_pop, q_full, q_empty;

    hill_key u_key (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    hill_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .coef     (coef),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    hill_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .entry_in  (push_entry),
        .full      (q_full),
        .pop       (q_pop),
        .entry_out (head_entry),
        .empty     (q_empty)
    );

    hill_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (head_entry),
        .q_pop     (q_pop),
        .coef      (coef),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ----- verif/tb_top.sv -----
// self-checking testbench for hill_2x2_decrypt_top: key phases, directed and random text
// depends on hill_pkg and the hill_2x2_decrypt_top rtl
module tb_top;
    import hill_pkg::*;

    localparam int unsigned LETTERS     = 26;
    localparam int unsigned LOWER_A     = 97;
    localparam int unsigned SETTLE      = 8;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned RAND_PHASES = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        cfg_we = 1'b0;
    cfg_index_t  cfg_index = CFG_KEY_A;
    logic [KEY_W-1:0] cfg_data = '0;

    // key copy and pairing state of the predictor
    logic [KEY_W-1:0]  key_now [4] = '{default: '0};
    logic [CHAR_W-1:0] held_char = '0;
    logic              pair_held = 1'b0;

    in_item_t    char_pending [$];
    out_item_t   plain_expected [$];
    int unsigned chars_queued = 0;
    int unsigned chars_taken = 0;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;

    // idle levels 0..3, 0 means no idling
    int unsigned send_idle = 0;
    int unsigned recv_idle = 0;
    int unsigned send_gap = 0;
    int unsigned recv_stall = 0;
    logic        drain_hold = 1'b0;

    hill_2x2_decrypt_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
        mismatches++;
    endtask

    // multiplicative inverse mod 26, zero when there is none
    function automatic int unsigned det_inverse(input int unsigned det);
        for (int unsigned m = 1; m < LETTERS; m++)
        begin
            if ((det * m) % LETTERS == 1)
            begin
                return m;
            end
        end
        return 0;
    endfunction

    function automatic int unsigned key_det_inverse(input int unsigned a, input int unsigned b,
                                                    input int unsigned c, input int unsigned d);
        return det_inverse(((a % LETTERS) * (d % LETTERS) + LETTERS * LETTERS
                            - (b % LETTERS) * (c % LETTERS)) % LETTERS);
    endfunction

    task automatic predict_plaintext(input in_item_t beat);
        int unsigned ka, kb, kc, kd, dinv, x0, x1;
        out_item_t   res;
        ka   = key_now[CFG_KEY_A] % LETTERS;
        kb   = key_now[CFG_KEY_B] % LETTERS;
        kc   = key_now[CFG_KEY_C] % LETTERS;
        kd   = key_now[CFG_KEY_D] % LETTERS;
        dinv = key_det_inverse(ka, kb, kc, kd);
        if (dinv == 0)
        begin
            // pass-through drops any half pair
            held_char          = '0;
            pair_held          = 1'b0;
            res.out_char       = beat.in_char;
            res.last_of_run    = 1'b1;
            res.key_invertible = 1'b0;
            plain_expected.push_back(res);
        end
        else if (!pair_held)
        begin
            held_char = beat.end_of_message ? '0 : beat.in_char;
            pair_held = !beat.end_of_message;
        end
        else
        begin
            x0 = (held_char + 10 * LETTERS - LOWER_A) % LETTERS;
            x1 = (beat.in_char + 10 * LETTERS - LOWER_A) % LETTERS;
            res.key_invertible = 1'b1;
            res.last_of_run    = 1'b0;
            res.out_char = 8'((((dinv * kd) % LETTERS) * x0
                               + ((dinv * ((LETTERS - kb) % LETTERS)) % LETTERS) * x1)
                              % LETTERS + LOWER_A);
            plain_expected.push_back(res);
            res.last_of_run = 1'b1;
            res.out_char = 8'((((dinv * ((LETTERS - kc) % LETTERS)) % LETTERS) * x0
                               + ((dinv * ka) % LETTERS) * x1) % LETTERS + LOWER_A);
            plain_expected.push_back(res);
            held_char = '0;
            pair_held = 1'b0;
        end
    endtask

    task automatic check_plaintext(input out_item_t got);
        out_item_t want;
        if (plain_expected.size() == 0)
        begin
            report_mismatch("unexpected beat, out_char", got.out_char, 0);
        end
        else
        begin
            want = plain_expected.pop_front();
            if (got.out_char !== want.out_char)
            begin
                report_mismatch("out_char", got.out_char, want.out_char);
            end
            if (got.last_of_run !== want.last_of_run)
            begin
                report_mismatch("last_of_run", got.last_of_run, want.last_of_run);
            end
            if (got.key_invertible !== want.key_invertible)
            begin
                report_mismatch("key_invertible", got.key_invertible, want.key_invertible);
            end
        end
    endtask

    // sender: holds a beat until taken, then a random gap or a drain pause
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_plaintext(in_data);
                chars_taken++;
                if (send_idle > 0 && $urandom_range(0, 9) < send_idle)
                begin
                    send_gap = $urandom_range(1, 9);
                end
                if (send_idle > 0 && $urandom_range(0, 59) == 0)
                begin
                    drain_hold = 1'b1;
                end
            end
            if (drain_hold && plain_expected.size() == 0)
            begin
                drain_hold = 1'b0;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (!drain_hold && char_pending.size() > 0)
                begin
                    in_data  <= char_pending.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each beat, stalls in bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                check_plaintext(out_data);
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (recv_idle > 0 && $urandom_range(0, 19) < recv_idle)
                begin
                    recv_stall = $urandom_range(1, 9);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic add_char(input logic [CHAR_W-1:0] ch, input logic eom);
        in_item_t beat;
        beat.in_char        = ch;
        beat.end_of_message = eom;
        char_pending.push_back(beat);
        chars_queued++;
    endtask

    task automatic add_random_char();
        logic [CHAR_W-1:0] ch;
        if ($urandom_range(0, 99) < 85)
        begin
            ch = CHAR_W'($urandom_range(LOWER_A, LOWER_A + LETTERS - 1));
        end
        else
        begin
            ch = CHAR_W'($urandom_range(0, 255));
        end
        add_char(ch, $urandom_range(0, 11) == 0);
    endtask

    // everything sent, taken and answered, then a settling wait
    task automatic wait_idle();
        while (chars_taken != chars_queued || plain_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_key(input cfg_index_t idx, input int unsigned val);
        @(posedge clk);
        cfg_we        <= 1'b1;
        cfg_index     <= idx;
        cfg_data      <= val[KEY_W-1:0];
        key_now[idx]   = val[KEY_W-1:0];
    endtask

    task automatic set_key(input int unsigned a, input int unsigned b,
                           input int unsigned c, input int unsigned d);
        write_key(CFG_KEY_A, a);
        write_key(CFG_KEY_B, b);
        write_key(CFG_KEY_C, c);
        write_key(CFG_KEY_D, d);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int unsigned ka, kb, kc, kd, n;
        logic        want_inv;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        send_idle = 1;
        recv_idle = 1;

        // reset key is singular: raw bytes come back, extremes included
        add_char(8'd0, 1'b0);
        add_char(8'd255, 1'b1);
        add_char("a", 1'b0);
        add_char("z", 1'b1);
        wait_idle();

        set_key(3, 3, 2, 5);
        add_char("a", 1'b0);
        add_char("z", 1'b0);
        add_char(8'd0, 1'b0);
        add_char(8'd255, 1'b0);
        add_char("q", 1'b1);   // odd final character, dropped
        add_char("h", 1'b0);
        add_char("x", 1'b1);   // end mark on the second character
        add_char("c", 1'b0);   // left held across the key change
        wait_idle();

        // entries above 25 reduce mod 26
        set_key(31, 29, 26, 27);
        add_char("k", 1'b0);
        add_char("m", 1'b0);
        add_char("n", 1'b0);
        add_char("b", 1'b0);
        wait_idle();

        // singular key discards the held character
        set_key(25, 25, 25, 25);
        add_char("e", 1'b0);
        add_char("f", 1'b1);
        wait_idle();

        set_key(25, 0, 0, 25);
        add_char("y", 1'b0);
        add_char("w", 1'b0);
        add_char("p", 1'b1);
        wait_idle();

        for (int unsigned ph = 0; ph < RAND_PHASES; ph++)
        begin
            want_inv = ($urandom_range(0, 3) != 0);
            do
            begin
                ka = $urandom_range(0, 31);
                kb = $urandom_range(0, 31);
                kc = $urandom_range(0, 31);
                kd = $urandom_range(0, 31);
            end
            while ((key_det_inverse(ka, kb, kc, kd) != 0) != want_inv);
            if (ph == RAND_PHASES - 1)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            else
            begin
                send_idle = $urandom_range(0, 3);
                recv_idle = $urandom_range(0, 3);
            end
            set_key(ka, kb, kc, kd);
            n = $urandom_range(200, 300);
            for (int unsigned i = 0; i < n; i++)
            begin
                add_random_char();
            end
            wait_idle();
        end

        if (mismatches == 0)
        begin
            $display("tb_top OK");
        end
        else
        begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
